### hdl/ugm_pkg.sv
// Shared types, constants and the font cell lookup for the UTF-8 glyph mapper.
// No dependencies; used by the channel interfaces and the core.
package ugm_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned CELL_W  = 7;
  localparam int unsigned RUN_W   = 3;  // up to four replacement results per item

  localparam logic [CP_W-1:0]   REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0]   CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0]   SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0]   SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0]   MIN_2BYTE   = 21'h000080;
  localparam logic [CP_W-1:0]   MIN_3BYTE   = 21'h000800;
  localparam logic [CP_W-1:0]   MIN_4BYTE   = 21'h010000;
  localparam logic [CP_W-1:0]   CYR_UPPER   = 21'h000410;
  localparam logic [CP_W-1:0]   CYR_LOWER   = 21'h000430;
  localparam logic [CP_W-1:0]   CYR_YO_UP   = 21'h000401;
  localparam logic [CP_W-1:0]   CYR_YO_LO   = 21'h000451;
  localparam logic [CELL_W-1:0] CELL_NOTDEF = 7'd95;
  localparam logic [CELL_W-1:0] CELL_CYR    = 7'd96;
  localparam logic [CELL_W-1:0] CELL_IE     = 7'd101;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [CELL_W-1:0] cell_t;

  function automatic cell_t cell_of(cp_t cp);
    cp_t off_up;
    cp_t off_lo;
    cp_t off_ascii;
    off_up    = cp - CYR_UPPER;
    off_lo    = cp - CYR_LOWER;
    off_ascii = cp - 21'd32;
    if (cp >= 21'd32 && cp <= 21'd126) begin
      cell_of = off_ascii[CELL_W-1:0];
    end else if (cp == CYR_YO_UP || cp == CYR_YO_LO) begin
      cell_of = CELL_IE;
    end else if (cp >= CYR_UPPER && cp < CYR_LOWER) begin
      cell_of = CELL_CYR | {2'b00, off_up[4:0]};
    end else if (cp >= CYR_LOWER && cp <= 21'h00044F) begin
      cell_of = CELL_CYR | {2'b00, off_lo[4:0]};
    end else begin
      cell_of = CELL_NOTDEF;
    end
  endfunction

endpackage

### hdl/ugm_if.sv
// Valid/ready channel interfaces for the UTF-8 glyph mapper: byte input and
// glyph result output. Depends on ugm_pkg.
interface ugm_in_if;
  import ugm_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ugm_out_if;
  import ugm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic [CELL_W-1:0] glyph_cell;
  logic              malformed;
  logic              last_of_run;

  modport source (output valid, output code_point, output glyph_cell, output malformed,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input glyph_cell, input malformed,
                  input last_of_run, output ready);
endinterface

### hdl/utf8_decoder_glyph_mapper_core.sv
// UTF-8 decoder with font cell mapping: top level.
// Depends on ugm_pkg and the ugm_in_if / ugm_out_if channel interfaces.
//
// Usage:
//   in_i  takes one text byte per item, end_of_text marks the final byte.
//   out_o gives decoded code points with their font cell, a malformed flag
//         and last_of_run on the final result caused by each byte.
//   Latency: a byte's first result is shown the cycle after it is accepted.
//   Throughput: one byte per cycle while each byte causes at most one result
//   and the receiver does not stall. A byte that causes k results (k up to
//   4, after a broken, rejected or truncated sequence) holds the result
//   register until all k are taken; in_i.ready rises again in the cycle its
//   last result is taken, so the next byte enters without a bubble. Bytes
//   that only extend a sequence cause no result.
//   When the receiver stalls, the pending result stays on out_o and in_i
//   stops taking bytes once that result register is full.
//   Reset clears the held sequence and drops any pending results; the block
//   is ready for a byte as soon as reset is released.
module utf8_decoder_glyph_mapper_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  ugm_in_if.sink   in_i,
  ugm_out_if.source out_o
);
  import ugm_pkg::*;

  // sequence state
  logic [1:0]        held_q, held_d;
  logic [1:0]        need_q, need_d;
  cp_t               part_q, part_d;

  // result run register: replacement count, then an optional tail result
  logic [RUN_W-1:0]  rep_q, rep_d;
  logic              tail_v_q, tail_v_d;
  cp_t               tail_cp_q, tail_cp_d;
  cell_t             tail_cell_q;
  logic              tail_bad_q, tail_bad_d;

  logic              in_acc, out_acc, out_last;

  // new-lead decode
  logic [BYTE_W-1:0] b;
  logic              st_tv, st_hold, st_bad;
  cp_t               st_cp, st_val;
  logic [1:0]        st_need;

  logic              is_cont;
  logic [RUN_W-1:0]  total;
  logic [1:0]        left;
  cp_t               val, shortest;

  assign b = in_i.in_byte;

  always_comb begin
    st_tv   = 1'b1;
    st_hold = 1'b0;
    st_bad  = 1'b0;
    st_cp   = {{(CP_W-BYTE_W){1'b0}}, b};
    st_val  = '0;
    st_need = 2'd0;
    if (b[7] == 1'b0) begin
      st_tv = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      st_hold = 1'b1;
      st_need = 2'd1;
      st_val  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      st_hold = 1'b1;
      st_need = 2'd2;
      st_val  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      st_hold = 1'b1;
      st_need = 2'd3;
      st_val  = {18'd0, b[2:0]};
    end else begin
      st_cp  = REPLACEMENT;
      st_bad = 1'b1;
    end
    if (st_hold) begin
      // a lead that arrives with end of text is truncated at once
      st_tv = in_i.end_of_text;
      st_cp = REPLACEMENT;
      st_bad = 1'b1;
      if (in_i.end_of_text) st_hold = 1'b0;
    end
  end

  assign is_cont = (b[7:6] == 2'b10);
  assign total   = {1'b0, held_q} + 3'd1;
  assign left    = need_q - 2'd1;
  assign val     = {part_q[CP_W-7:0], b[5:0]};

  always_comb begin
    case (total)
      3'd2:    shortest = MIN_2BYTE;
      3'd3:    shortest = MIN_3BYTE;
      default: shortest = MIN_4BYTE;
    endcase
  end

  always_comb begin
    rep_d      = '0;
    tail_v_d   = 1'b0;
    tail_cp_d  = st_cp;
    tail_bad_d = 1'b0;
    held_d     = 2'd0;
    need_d     = 2'd0;
    part_d     = '0;
    if (held_q == 2'd0 || need_q == 2'd0 || !is_cont) begin
      // idle, or a sequence broken by a non-continuation byte
      if (held_q != 2'd0 && need_q != 2'd0) rep_d = {1'b0, held_q};
      tail_v_d   = st_tv;
      tail_cp_d  = st_cp;
      tail_bad_d = st_bad;
      if (st_hold) begin
        held_d = 2'd1;
        need_d = st_need;
        part_d = st_val;
      end
    end else if (left == 2'd0) begin
      if (val < shortest || val > CP_MAX || (val >= SURR_LO && val <= SURR_HI)) begin
        rep_d = total;
      end else begin
        tail_v_d  = 1'b1;
        tail_cp_d = val;
      end
    end else if (in_i.end_of_text) begin
      rep_d = total;
    end else begin
      held_d = total[1:0];
      need_d = left;
      part_d = val;
    end
  end

  assign out_last    = (rep_q == 3'd1 && !tail_v_q) || (rep_q == 3'd0 && tail_v_q);
  assign out_o.valid = (rep_q != 3'd0) || tail_v_q;
  assign in_i.ready  = !out_o.valid || (out_o.ready && out_last);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;

  assign out_o.code_point  = (rep_q != 3'd0) ? REPLACEMENT : tail_cp_q;
  assign out_o.glyph_cell  = (rep_q != 3'd0) ? CELL_NOTDEF : tail_cell_q;
  assign out_o.malformed   = (rep_q != 3'd0) ? 1'b1 : tail_bad_q;
  assign out_o.last_of_run = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 2'd0;
      need_q   <= 2'd0;
      part_q   <= '0;
      rep_q    <= '0;
      tail_v_q <= 1'b0;
    end else if (in_acc) begin
      held_q   <= held_d;
      need_q   <= need_d;
      part_q   <= part_d;
      rep_q    <= rep_d;
      tail_v_q <= tail_v_d;
    end else if (out_acc) begin
      if (rep_q != 3'd0) begin
        rep_q <= rep_q - 3'd1;
      end else begin
        tail_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tail_cp_q   <= tail_cp_d;
      tail_cell_q <= cell_of(tail_cp_d);
      tail_bad_q  <= tail_bad_d;
    end
  end

`ifndef NO_ASSERTIONS
  // no new byte while results of the previous one remain after this cycle
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !(out_o.ready && out_last) |-> !in_i.ready)
    else $error("input accepted while results still pending");

  // a held sequence never claims more than four bytes in total
  a_seq_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != 2'd0 && need_q != 2'd0 |-> ({1'b0, held_q} + {1'b0, need_q}) <= 3'd4)
    else $error("held sequence longer than four bytes");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q <= 3'd4)
    else $error("replacement run longer than four");

  a_bad_is_fffd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.malformed |->
      out_o.code_point == REPLACEMENT && out_o.glyph_cell == CELL_NOTDEF)
    else $error("malformed result is not the replacement character");
`endif

endmodule

### tb/tb_utf8_decoder_glyph_mapper_core.sv
// Testbench for utf8_decoder_glyph_mapper_core: a directed byte table, then random
// UTF-8 text under several idle mixes, checked against an in-bench decoder model.
// Depends on ugm_pkg and the ugm_in_if / ugm_out_if channel interfaces.
module tb_utf8_decoder_glyph_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ugm_pkg::*;

  typedef logic [BYTE_W-1:0] text_byte_t;

  typedef struct packed {
    cp_t   code_point;
    cell_t glyph_cell;
    logic  malformed;
    logic  last_of_run;
  } glyph_t;

  typedef struct packed {
    text_byte_t b;
    logic       eot;
  } text_item_t;

  // Directed row: typed rows carry n identical results, the others use the model.
  typedef struct packed {
    text_byte_t b;
    logic       eot;
    logic       typed;
    logic [2:0] n;
    cp_t        cp;
    cell_t      cell_idx;
    logic       bad;
  } dir_row_t;

  localparam int DIR_N = 28;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'h41, 1'b0, 1'b1, 3'd1, 21'h000041, 7'd33, 1'b0},  // 'A' right after reset
    '{8'h20, 1'b0, 1'b1, 3'd1, 21'h000020, 7'd0,  1'b0},  // first printable
    '{8'h7E, 1'b0, 1'b1, 3'd1, 21'h00007E, 7'd94, 1'b0},  // last printable
    '{8'h00, 1'b0, 1'b1, 3'd1, 21'h000000, 7'd95, 1'b0},  // zero byte
    '{8'h80, 1'b0, 1'b1, 3'd1, 21'h00FFFD, 7'd95, 1'b1},  // bad lead, continuation
    '{8'hFF, 1'b0, 1'b1, 3'd1, 21'h00FFFD, 7'd95, 1'b1},  // bad lead, top byte
    '{8'hD0, 1'b0, 1'b1, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h90, 1'b0, 1'b1, 3'd1, 21'h000410, 7'd96, 1'b0},  // first Cyrillic capital
    '{8'hD1, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h91, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},  // small yo
    '{8'hC0, 1'b0, 1'b1, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd2, 21'h00FFFD, 7'd95, 1'b1},  // overlong two-byte
    '{8'hED, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'hA0, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},  // surrogate
    '{8'hF4, 1'b0, 1'b1, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h90, 1'b0, 1'b1, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h80, 1'b0, 1'b1, 3'd4, 21'h00FFFD, 7'd95, 1'b1},  // above the last scalar
    '{8'hF4, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h8F, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'hBF, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'hBF, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},  // last scalar
    '{8'hE2, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h41, 1'b0, 1'b0, 3'd0, 21'h0,      7'd0,  1'b0},  // broken sequence
    '{8'hE2, 1'b0, 1'b1, 3'd0, 21'h0,      7'd0,  1'b0},
    '{8'h82, 1'b1, 1'b1, 3'd2, 21'h00FFFD, 7'd95, 1'b1},  // truncated by end of text
    '{8'hC3, 1'b1, 1'b1, 3'd1, 21'h00FFFD, 7'd95, 1'b1}   // lead with end of text
  };

  localparam int SEND_IDLE  [4] = '{0, 69, 0, 21};
  localparam int RECV_STALL [4] = '{0, 0, 69, 21};
  localparam int HOLD_CYCLES    = 60;

  logic clk;
  logic rst_n;

  ugm_in_if  in_if ();
  ugm_out_if out_if ();

  utf8_decoder_glyph_mapper_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // decoder model state
  logic [1:0] seq_held;
  logic [1:0] seq_need;
  cp_t        seq_bits;

  glyph_t     pending_glyphs [$];
  glyph_t     step_glyphs [$];
  text_item_t text_plan [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  logic hold_rx;
  bit  pressure_go;
  int  err_cnt;
  int  bytes_sent;
  int  glyphs_seen;
  int  bad_seen;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic cell_t font_cell(cp_t cp);
    if (cp >= 21'd32 && cp <= 21'd126) return cell_t'(cp - 21'd32);
    if (cp == CYR_YO_UP || cp == CYR_YO_LO) return CELL_IE;
    if (cp >= CYR_UPPER && cp <= 21'h00042F) return cell_t'(CELL_CYR + (cp - CYR_UPPER));
    if (cp >= CYR_LOWER && cp <= 21'h00044F) return cell_t'(CELL_CYR + (cp - CYR_LOWER));
    return CELL_NOTDEF;
  endfunction

  function automatic void add_result(cp_t cp, logic bad);
    glyph_t g;
    g.code_point  = cp;
    g.glyph_cell  = font_cell(cp);
    g.malformed   = bad;
    g.last_of_run = 1'b0;
    step_glyphs.push_back(g);
  endfunction

  function automatic void clear_seq();
    seq_held = '0;
    seq_need = '0;
    seq_bits = '0;
  endfunction

  function automatic void start_lead(text_byte_t b, logic eot);
    logic [1:0] n;
    cp_t        v;
    bit         bad_lead;
    bad_lead = 1'b0;
    n = '0;
    v = '0;
    if (!b[7]) begin
      add_result(cp_t'(b), 1'b0);
    end else begin
      if (b[7:5] == 3'b110) begin
        n = 2'd1;
        v = cp_t'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        n = 2'd2;
        v = cp_t'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        n = 2'd3;
        v = cp_t'(b[2:0]);
      end else begin
        bad_lead = 1'b1;
      end
      if (bad_lead) begin
        add_result(REPLACEMENT, 1'b1);
      end else if (eot) begin
        add_result(REPLACEMENT, 1'b1);
        clear_seq();
      end else begin
        seq_held = 2'd1;
        seq_need = n;
        seq_bits = v;
      end
    end
  endfunction

  // One accepted byte: fills step_glyphs with the results it causes.
  function automatic void decode_byte(text_byte_t b, logic eot);
    logic [2:0] total;
    logic [1:0] left;
    cp_t        val;
    cp_t        shortest;
    int         h;
    glyph_t     g;
    step_glyphs.delete();
    if (seq_held == 2'd0 || seq_need == 2'd0) begin
      clear_seq();
      start_lead(b, eot);
    end else if (b[7:6] == 2'b10) begin
      total = {1'b0, seq_held} + 3'd1;
      val   = {seq_bits[14:0], b[5:0]};
      left  = seq_need - 2'd1;
      if (left == 2'd0) begin
        shortest = (total == 3'd2) ? MIN_2BYTE : (total == 3'd3) ? MIN_3BYTE : MIN_4BYTE;
        if (val < shortest || val > CP_MAX || (val >= SURR_LO && val <= SURR_HI)) begin
          repeat (total) add_result(REPLACEMENT, 1'b1);
        end else begin
          add_result(val, 1'b0);
        end
        clear_seq();
      end else if (eot) begin
        repeat (total) add_result(REPLACEMENT, 1'b1);
        clear_seq();
      end else begin
        seq_held = total[1:0];
        seq_need = left;
        seq_bits = val;
      end
    end else begin
      h = seq_held;
      repeat (h) add_result(REPLACEMENT, 1'b1);
      clear_seq();
      start_lead(b, eot);
    end
    if (step_glyphs.size() > 0) begin
      g = step_glyphs.pop_back();
      g.last_of_run = 1'b1;
      step_glyphs.push_back(g);
    end
  endfunction

  function automatic void queue_predicted(text_byte_t b, logic eot);
    decode_byte(b, eot);
    foreach (step_glyphs[i]) pending_glyphs.push_back(step_glyphs[i]);
  endfunction

  function automatic int utf8_len(cp_t cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Encode cp in len bytes whatever its value; only the first keep bytes are queued.
  function automatic void plan_seq(cp_t cp, int len, int keep, logic eot_last);
    text_byte_t seq [4];
    text_item_t it;
    case (len)
      1: seq[0] = cp[7:0];
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) begin
      it.b   = seq[i];
      it.eot = eot_last && (i == keep - 1);
      text_plan.push_back(it);
    end
  endfunction

  function automatic cp_t pick_scalar();
    cp_t cp;
    int  k;
    k = $urandom_range(9);
    if (k < 3) begin
      cp = cp_t'($urandom_range(8'h7F));
    end else if (k < 5) begin
      cp = cp_t'($urandom_range(21'h400, 21'h45F));
    end else if (k == 5) begin
      cp = cp_t'($urandom_range(21'h80, 21'h7FF));
    end else if (k == 6) begin
      cp = cp_t'($urandom_range(21'h800, 21'hFFFF));
      if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h2000;
    end else if (k == 7) begin
      cp = cp_t'($urandom_range(21'h10000, 21'h10FFFF));
    end else begin
      case ($urandom_range(8))
        0: cp = 21'h7F;
        1: cp = 21'h80;
        2: cp = 21'h7FF;
        3: cp = 21'h800;
        4: cp = 21'hD7FF;
        5: cp = 21'hE000;
        6: cp = 21'hFFFF;
        7: cp = 21'h10000;
        default: cp = CP_MAX;
      endcase
    end
    return cp;
  endfunction

  // Mostly well-formed text; the rest is noise, truncation and rejected forms.
  function automatic void add_chunk();
    int         k;
    int         len;
    cp_t        cp;
    text_item_t it;
    k = $urandom_range(99);
    if (k < 60) begin
      cp = pick_scalar();
      plan_seq(cp, utf8_len(cp), utf8_len(cp), $urandom_range(11) == 0);
    end else if (k < 70) begin
      repeat ($urandom_range(1, 3)) begin
        it.b   = text_byte_t'($urandom);
        it.eot = $urandom_range(15) == 0;
        text_plan.push_back(it);
      end
    end else if (k < 80) begin
      cp  = cp_t'($urandom_range(21'h80, 21'h10FFFF));
      len = utf8_len(cp);
      plan_seq(cp, len, $urandom_range(1, len - 1), $urandom_range(1) == 1);
    end else if (k < 95) begin
      case ($urandom_range(2))
        0: begin
          len = $urandom_range(2, 4);
          cp  = (len == 2) ? cp_t'($urandom_range(8'h7F)) :
                (len == 3) ? cp_t'($urandom_range(21'h7FF)) : cp_t'($urandom_range(21'hFFFF));
        end
        1: begin
          len = 3;
          cp  = SURR_LO + cp_t'($urandom_range(21'h7FF));
        end
        default: begin
          len = 4;
          cp  = cp_t'($urandom_range(21'h110000, 21'h1FFFFF));
        end
      endcase
      plan_seq(cp, len, len, 1'b0);
    end else begin
      repeat ($urandom_range(1, 2)) begin
        it.b   = 8'h80 | text_byte_t'($urandom_range(63));
        it.eot = 1'b0;
        text_plan.push_back(it);
      end
    end
  endfunction

  task automatic offer_byte(text_byte_t b, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.in_byte     <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n_items);
    text_item_t it;
    while (text_plan.size() < n_items) add_chunk();
    while (text_plan.size() > 0) begin
      it = text_plan.pop_front();
      offer_byte(it.b, it.eot);
      queue_predicted(it.b, it.eot);
    end
    wait_drained();
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin : result_check
    glyph_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        glyphs_seen++;
        if (out_if.malformed) bad_seen++;
        if (pending_glyphs.size() == 0) begin
          $error("unexpected result: code_point %h", out_if.code_point);
          err_cnt++;
        end else begin
          want = pending_glyphs.pop_front();
          if (out_if.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, out_if.code_point);
            err_cnt++;
          end
          if (out_if.glyph_cell !== want.glyph_cell) begin
            $error("glyph_cell: expected %0d, got %0d", want.glyph_cell, out_if.glyph_cell);
            err_cnt++;
          end
          if (out_if.malformed !== want.malformed) begin
            $error("malformed: expected %b, got %b", want.malformed, out_if.malformed);
            err_cnt++;
          end
          if (out_if.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, out_if.last_of_run);
            err_cnt++;
          end
        end
      end
    end
    out_if.ready <= rst_n && !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the core backs up into its input
  initial begin
    hold_rx = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_if.valid       <= 1'b0;
    in_if.in_byte     <= '0;
    in_if.end_of_text <= 1'b0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_go    = 1'b0;
    err_cnt        = 0;
    bytes_sent     = 0;
    glyphs_seen    = 0;
    bad_seen       = 0;
    clear_seq();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      offer_byte(DIR_TAB[r].b, DIR_TAB[r].eot);
      if (DIR_TAB[r].typed) begin
        decode_byte(DIR_TAB[r].b, DIR_TAB[r].eot);  // keeps the model state in step
        for (int i = 0; i < DIR_TAB[r].n; i++) begin
          pending_glyphs.push_back('{DIR_TAB[r].cp, DIR_TAB[r].cell_idx, DIR_TAB[r].bad,
                                     i == DIR_TAB[r].n - 1});
        end
      end else begin
        queue_predicted(DIR_TAB[r].b, DIR_TAB[r].eot);
      end
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      run_random(17);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_go    = 1'b1;
    run_random(12);

    repeat (10) @(posedge clk);
    $display("Sent %0d bytes: directed edge cases, four idle mixes and a receiver hold-off.",
             bytes_sent);
    $display("Checked %0d results, %0d of them malformed.", glyphs_seen, bad_seen);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ugm_pkg.sv
hdl/ugm_if.sv
hdl/utf8_decoder_glyph_mapper_core.sv
tb/tb_utf8_decoder_glyph_mapper_core.sv
